/* sv/egkvq_pkg.sv */
// ----------------------------------------------------------------------------
// egkvq_pkg
// Shared types and constants for the entropy gated key/value quantizer.
// ----------------------------------------------------------------------------
package egkvq_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_HEADS = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTROPY_THRESHOLD = 1'b0,
        REG_WINDOW_LIMIT      = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_QUANT = 1'b0,
        CMD_ADAPT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PREC_16 = 2'd0,
        PREC_8  = 2'd1,
        PREC_4  = 2'd2
    } prec_t;

    localparam logic [15:0] RESET_THRESHOLD = 16'd256;
    localparam logic [15:0] RESET_LIMIT     = 16'd64;

    localparam logic        [30:0] U16_SCALE = 31'd65535;
    localparam logic signed [23:0] Q8_SCALE  = 24'sd127;
    localparam logic signed [23:0] Q8_BIAS   = 24'sd4194304;
    localparam logic signed [19:0] Q4_SCALE  = 20'sd7;
    localparam logic signed [19:0] Q4_BIAS   = 20'sd262144;

    typedef struct packed {
        logic               cmd;
        logic        [4:0]  head;
        logic        [15:0] seq_pos;
        logic        [15:0] entropy;
        logic signed [15:0] sample;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [1:0] precision;
        logic       final_byte;
    } result_t;

    typedef struct packed {
        prec_t       precision;
        logic [15:0] code16;
        logic [7:0]  code8;
        logic [3:0]  code4;
    } enc_t;

endpackage

/* sv/egkvq_if.sv */
// ----------------------------------------------------------------------------
// egkvq interfaces
// Valid/ready channels for element items and packed code bytes.
// ----------------------------------------------------------------------------
interface egkvq_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic        [4:0]  head;
    logic        [15:0] seq_pos;
    logic        [15:0] entropy;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, cmd, head, seq_pos, entropy, sample, last, input ready);
    modport sink   (input valid, cmd, head, seq_pos, entropy, sample, last, output ready);
endinterface

interface egkvq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic [1:0] precision;
    logic       final_byte;

    modport source (output valid, code_byte, precision, final_byte, input ready);
    modport sink   (input valid, code_byte, precision, final_byte, output ready);
endinterface

/* sv/egkvq_encode.sv */
// ----------------------------------------------------------------------------
// egkvq_encode
// Precision select and 16/8/4-bit code computation for one element.
// ----------------------------------------------------------------------------
module egkvq_encode
    import egkvq_pkg::*;
(
    input  item_t       item,
    input  logic [15:0] window,
    input  logic [15:0] threshold,
    output enc_t        enc
);

    logic        [30:0] prod16;
    logic signed [23:0] sum8;
    logic signed [19:0] sum4;

    always_comb
    begin
        prod16 = 31'(item.sample[14:0]) * U16_SCALE;
        sum8   = $signed({{8{item.sample[15]}}, item.sample}) * Q8_SCALE + Q8_BIAS;
        sum4   = $signed({{4{item.sample[15]}}, item.sample}) * Q4_SCALE + Q4_BIAS;

        enc.code16 = item.sample[15] ? 16'd0 : prod16[30:15];
        // biased sums stay positive and inside the code range
        enc.code8  = sum8[22:15];
        enc.code4  = sum4[18:15];

        if ((item.seq_pos < window) || (item.entropy > threshold))
        begin
            enc.precision = PREC_16;
        end
        else if ({item.entropy, 1'b0} > {1'b0, threshold})
        begin
            enc.precision = PREC_8;
        end
        else
        begin
            enc.precision = PREC_4;
        end
    end

endmodule

/* sv/entropy_gated_kv_quantizer.sv */
// ----------------------------------------------------------------------------
// entropy_gated_kv_quantizer
// Per-element precision choice and byte packing of key/value data, with
// per-head recent windows adapted by entropy.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      cmd head seq_pos entropy sample last
//  out_ch    out  valid/ready      code_byte precision final_byte
//  cfg       in   cfg_we           cfg_index cfg_data
//
//  One item per cycle enters the item register while its bytes fit in the buffer;
//  it is encoded and its bytes land in a two-entry output buffer when it fires.
//  A 16-bit item yields two bytes, an 8-bit item one, and two 4-bit items share
//  one byte; the single byte output port limits the sustained rate.
//  Reset clears windows, nibble state and the buffer count, and loads the config defaults.
//  An output stall holds the item register once its bytes do not fit.
// ----------------------------------------------------------------------------
module entropy_gated_kv_quantizer
    import egkvq_pkg::*;
#(
    parameter int WINDOW_STEP = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    egkvq_in_if.sink             in_ch,
    egkvq_out_if.source          out_ch
);

    localparam int          HEAD_W = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam logic [16:0] STEP   = 17'(WINDOW_STEP);

    logic [15:0] threshold_reg;
    logic [15:0] limit_reg;
    logic [15:0] window_reg [NUM_HEADS];
    item_t       item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [3:0]  held_reg;
    logic [3:0]  held_next;
    logic        pending_reg;
    logic        pending_next;
    result_t     slot_reg [2];
    result_t     slot_next [2];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    item_t       item_in;
    logic        in_xfer;
    logic [HEAD_W-1:0] hidx;
    logic [15:0] win;
    logic [15:0] win_upd;
    logic [16:0] grown;
    enc_t        enc;
    logic [1:0]  n_res;
    result_t     r0;
    result_t     r1;
    logic        pop;
    logic [1:0]  cnt_pop;
    logic        fire;

    assign item_in = '{cmd:     in_ch.cmd,
                       head:    in_ch.head,
                       seq_pos: in_ch.seq_pos,
                       entropy: in_ch.entropy,
                       sample:  in_ch.sample,
                       last:    in_ch.last};

    assign hidx = item_reg.head[HEAD_W-1:0];
    assign win  = window_reg[hidx];

    egkvq_encode u_encode
    (
        .item      (item_reg),
        .window    (win),
        .threshold (threshold_reg),
        .enc       (enc)
    );

    always_comb
    begin
        n_res        = 2'd0;
        r0           = '0;
        r1           = '0;
        pending_next = pending_reg;
        held_next    = held_reg;
        win_upd      = win;
        grown        = {1'b0, win} + STEP;

        if (item_reg.cmd == CMD_ADAPT)
        begin
            if ({item_reg.entropy, 1'b0} < {1'b0, threshold_reg})
            begin
                win_upd = (grown < {1'b0, limit_reg}) ? grown[15:0] : limit_reg;
            end
            else if (item_reg.entropy > threshold_reg)
            begin
                win_upd = ({1'b0, win} > STEP) ? 16'({1'b0, win} - STEP) : 16'd0;
            end
        end
        else
        begin
            case (enc.precision)
                PREC_16:
                begin
                    n_res        = 2'd2;
                    r0           = '{enc.code16[7:0], PREC_16, 1'b0};
                    r1           = '{enc.code16[15:8], PREC_16, item_reg.last};
                    pending_next = 1'b0;
                end
                PREC_8:
                begin
                    n_res        = 2'd1;
                    r0           = '{enc.code8, PREC_8, item_reg.last};
                    pending_next = 1'b0;
                end
                PREC_4:
                begin
                    if (pending_reg)
                    begin
                        n_res        = 2'd1;
                        r0           = '{{enc.code4, held_reg}, PREC_4, item_reg.last};
                        pending_next = 1'b0;
                        held_next    = 4'd0;
                    end
                    else if (item_reg.last)
                    begin
                        n_res = 2'd1;
                        r0    = '{{4'd0, enc.code4}, PREC_4, 1'b1};
                    end
                    else
                    begin
                        held_next    = enc.code4;
                        pending_next = 1'b1;
                    end
                end
                default:
                begin
                    n_res = 2'd0;
                end
            endcase
        end
    end

    assign pop     = (cnt_reg != 2'd0) && out_ch.ready;
    assign cnt_pop = cnt_reg - {1'b0, pop};
    assign fire    = item_valid_reg && (n_res <= (2'd2 - cnt_pop));

    assign in_ch.ready = !item_valid_reg || fire;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = (cnt_reg != 2'd0);
    assign out_ch.code_byte  = slot_reg[0].code_byte;
    assign out_ch.precision  = slot_reg[0].precision;
    assign out_ch.final_byte = slot_reg[0].final_byte;

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_pop;
        if (fire && (n_res != 2'd0))
        begin
            cnt_next = cnt_pop + n_res;
            if (cnt_pop == 2'd0)
            begin
                slot_next[0] = r0;
                slot_next[1] = r1;
            end
            else
            begin
                slot_next[1] = r0;
            end
        end

        item_valid_next = in_xfer ? 1'b1 : (fire ? 1'b0 : item_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= RESET_THRESHOLD;
            limit_reg      <= RESET_LIMIT;
            item_valid_reg <= 1'b0;
            held_reg       <= 4'd0;
            pending_reg    <= 1'b0;
            cnt_reg        <= 2'd0;
            for (int i = 0; i < NUM_HEADS; i++)
            begin
                window_reg[i] <= 16'd0;
            end
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
            if (fire)
            begin
                held_reg    <= held_next;
                pending_reg <= pending_next;
                window_reg[hidx] <= win_upd;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTROPY_THRESHOLD: threshold_reg <= cfg_data;
                    REG_WINDOW_LIMIT:      limit_reg     <= cfg_data;
                    default:               threshold_reg <= threshold_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_in;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

/* sv/egkvq_checker.sv */
// ----------------------------------------------------------------------------
// egkvq_checker
// Port-level checks of the quantizer output buffer and back-pressure.
// ----------------------------------------------------------------------------
module egkvq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] code_byte,
    input logic [1:0] precision,
    input logic       final_byte
);

    // empty buffer while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // hold a stalled transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_byte)
            && $stable(precision) && $stable(final_byte))
        else $error("stalled output changed");

    // no progress on the input while the output stays stalled
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !in_ready) ##1 !out_ready |-> !in_ready)
        else $error("input advanced with stalled full buffer");

    // precision code three is never emitted
    a_prec_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> precision != 2'd3)
        else $error("undefined precision code");

endmodule

bind entropy_gated_kv_quantizer egkvq_checker u_egkvq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .code_byte  (out_ch.code_byte),
    .precision  (out_ch.precision),
    .final_byte (out_ch.final_byte)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the entropy gated key/value quantizer byte by byte. A scoreboard
// predicts the packed code bytes of every accepted element from its own copy
// of the head windows, the held nibble and the two registers. Directed
// elements cover each precision, the nibble pairing and the window
// adaptation. Random tokens follow under several register settings, with
// random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import egkvq_pkg::*;

    localparam int WINDOW_STEP     = 8;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT     = 3000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_ITEMS     = 140;
    localparam int NUM_PHASES      = 5;

    class quant_scoreboard;
        logic [15:0] threshold;
        logic [15:0] limit;
        logic [15:0] window [NUM_HEADS];
        logic [3:0]  held;
        bit          held_valid;
        result_t     expected_bytes [$];
        int          failures;

        function new();
            threshold  = RESET_THRESHOLD;
            limit      = RESET_LIMIT;
            held       = '0;
            held_valid = 1'b0;
            failures   = 0;
            foreach (window[i])
                window[i] = '0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [15:0] val);
            if (idx == REG_ENTROPY_THRESHOLD)
                threshold = val;
            else
                limit = val;
        endfunction

        function void push_byte(logic [7:0] code, prec_t prec, logic fin);
            result_t r;
            r.code_byte  = code;
            r.precision  = prec;
            r.final_byte = fin;
            expected_bytes.push_back(r);
        endfunction

        function void accept_element(item_t it);
            int unsigned h;
            int unsigned win;
            int unsigned ent2;
            int unsigned code;
            int          s;
            int          v;
            h    = it.head % NUM_HEADS;
            win  = 32'(window[h]);
            ent2 = 32'({it.entropy, 1'b0});
            s    = int'($signed(it.sample));
            if (it.cmd == CMD_ADAPT)
            begin
                if (ent2 < threshold)
                begin
                    win = win + WINDOW_STEP;
                    window[h] = (win < limit) ? 16'(win) : limit;
                end
                else if (it.entropy > threshold)
                begin
                    window[h] = (win > WINDOW_STEP) ? 16'(win - WINDOW_STEP) : 16'd0;
                end
                return;
            end
            if (it.seq_pos < win || it.entropy > threshold)
            begin
                code = (s >= 0) ? ((s * 65535) >> 15) : 0;
                held_valid = 1'b0;
                push_byte(code[7:0], PREC_16, 1'b0);
                push_byte(code[15:8], PREC_16, it.last);
                return;
            end
            if (ent2 > threshold)
            begin
                v = (s * 127 + 4194304) / 32768;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                held_valid = 1'b0;
                push_byte(v[7:0], PREC_8, it.last);
                return;
            end
            v = (s * 7 + 262144) / 32768;
            if (v < 0)
                v = 0;
            if (v > 15)
                v = 15;
            if (held_valid)
            begin
                push_byte({v[3:0], held}, PREC_4, it.last);
                held_valid = 1'b0;
                held       = '0;
            end
            else if (it.last)
            begin
                push_byte({4'h0, v[3:0]}, PREC_4, 1'b1);
            end
            else
            begin
                held       = v[3:0];
                held_valid = 1'b1;
            end
        endfunction

        function void check_byte(result_t got);
            result_t want;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected byte %02h prec %0d final %0d",
                             got.code_byte, got.precision, got.final_byte);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"byte mismatch: expected %02h prec %0d final %0d, ",
                              "got %02h prec %0d final %0d"},
                             want.code_byte, want.precision, want.final_byte,
                             got.code_byte, got.precision, got.final_byte);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    egkvq_in_if  in_ch ();
    egkvq_out_if out_ch ();

    quant_scoreboard sb = new();

    bit in_xfer;
    bit out_xfer;
    bit steady;
    bit hold_off_req;
    int stuck_cycles;

    entropy_gated_kv_quantizer #(
        .WINDOW_STEP (WINDOW_STEP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        item_t   it;
        result_t r;
        in_xfer  = rst_n && in_ch.valid && in_ch.ready;
        out_xfer = rst_n && out_ch.valid && out_ch.ready;
        if (in_xfer)
        begin
            it.cmd     = in_ch.cmd;
            it.head    = in_ch.head;
            it.seq_pos = in_ch.seq_pos;
            it.entropy = in_ch.entropy;
            it.sample  = in_ch.sample;
            it.last    = in_ch.last;
            sb.accept_element(it);
        end
        if (out_xfer)
        begin
            r.code_byte  = out_ch.code_byte;
            r.precision  = out_ch.precision;
            r.final_byte = out_ch.final_byte;
            sb.check_byte(r);
        end
        if (in_xfer || out_xfer || !rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL entropy_gated_kv_quantizer");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic item_t make_item(cmd_t c, int unsigned h, int unsigned pos,
                                        int unsigned ent, int smp, bit lst);
        item_t it;
        it.cmd     = c;
        it.head    = h[4:0];
        it.seq_pos = pos[15:0];
        it.entropy = ent[15:0];
        it.sample  = smp[15:0];
        it.last    = lst;
        return it;
    endfunction

    function automatic int unsigned clamp16(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic int unsigned pick_entropy();
        int thr;
        thr = int'(sb.threshold);
        case ($urandom_range(0, 8))
            0: return 0;
            1: return thr / 2;
            2: return clamp16(thr / 2 + 1);
            3: return clamp16(thr / 2 - 1);
            4: return thr;
            5: return clamp16(thr + 1);
            6: return 65535;
            7: return $urandom_range(thr / 2, thr);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned pick_pos(int unsigned h);
        int win;
        win = int'(sb.window[h]);
        case ($urandom_range(0, 3))
            0: return clamp16(win - 1);
            1: return win;
            2: return $urandom_range(0, 100);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 2) - 1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic send_element(item_t it);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= it.cmd;
        in_ch.head    <= it.head;
        in_ch.seq_pos <= it.seq_pos;
        in_ch.entropy <= it.entropy;
        in_ch.sample  <= it.sample;
        in_ch.last    <= it.last;
        do
            @(negedge clk);
        while (!in_xfer);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_token(inout int sent);
        int unsigned h;
        int unsigned pos;
        int unsigned ent;
        int          n;
        int          r;
        bit          lst;
        h = $urandom_range(0, NUM_HEADS - 1);
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            send_element(make_item(CMD_ADAPT, h, $urandom_range(0, 65535), pick_entropy(),
                                   pick_sample(), $urandom_range(0, 1)));
            sent++;
        end
        else if (r < 22)
        begin
            send_element(make_item(cmd_t'($urandom_range(0, 1)), h, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), pick_sample(),
                                   $urandom_range(0, 1)));
            sent++;
        end
        else
        begin
            n   = $urandom_range(1, 6);
            pos = pick_pos(h);
            ent = pick_entropy();
            for (int i = 0; i < n; i++)
            begin
                lst = (i == n - 1) && ($urandom_range(0, 9) != 0);
                send_element(make_item(CMD_QUANT, h, pos, ent, pick_sample(), lst));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [15:0] thr_set [NUM_PHASES];
        logic [15:0] lim_set [NUM_PHASES];
        int          sent;
        bit          pressure_done;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENTROPY_THRESHOLD;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_QUANT;
        in_ch.head    = '0;
        in_ch.seq_pos = '0;
        in_ch.entropy = '0;
        in_ch.sample  = '0;
        in_ch.last    = 1'b0;
        steady        = 1'b0;
        hold_off_req  = 1'b0;
        pressure_done = 1'b0;
        stuck_cycles  = 0;

        thr_set = '{RESET_THRESHOLD, 16'd0, 16'd65535, 16'd512, 16'($urandom_range(0, 65535))};
        lim_set = '{RESET_LIMIT, 16'd0, 16'd65535, 16'd16, 16'($urandom_range(0, 65535))};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_element(make_item(CMD_QUANT, 0, 0, 0, 32767, 0));
        send_element(make_item(CMD_QUANT, 0, 0, 0, -32768, 1));
        send_element(make_item(CMD_QUANT, 1, 65535, 0, 0, 1));
        send_element(make_item(CMD_QUANT, 2, 0, 129, 32767, 0));
        send_element(make_item(CMD_QUANT, 2, 0, 128, -32768, 1));
        send_element(make_item(CMD_QUANT, 3, 0, 256, -32768, 1));
        send_element(make_item(CMD_QUANT, 3, 0, 257, 32767, 1));
        send_element(make_item(CMD_QUANT, 3, 0, 65535, -32768, 0));
        send_element(make_item(CMD_QUANT, 4, 0, 300, 1, 1));
        send_element(make_item(CMD_QUANT, 5, 0, 0, -1, 0));
        send_element(make_item(CMD_QUANT, 5, 0, 300, 0, 1));
        send_element(make_item(CMD_QUANT, 5, 0, 0, 16384, 0));
        send_element(make_item(CMD_QUANT, 5, 0, 200, -16384, 1));
        send_element(make_item(CMD_QUANT, 6, 0, 0, 100, 0));
        send_element(make_item(CMD_ADAPT, 6, 0, 0, 0, 0));
        send_element(make_item(CMD_QUANT, 6, 8, 0, -100, 1));
        send_element(make_item(CMD_ADAPT, 0, 0, 0, 0, 0));
        send_element(make_item(CMD_ADAPT, 0, 0, 127, 0, 0));
        send_element(make_item(CMD_QUANT, 0, 15, 0, 12345, 1));
        send_element(make_item(CMD_QUANT, 0, 16, 0, 12345, 1));
        send_element(make_item(CMD_ADAPT, 0, 0, 128, 0, 0));
        send_element(make_item(CMD_ADAPT, 0, 0, 257, 0, 0));
        send_element(make_item(CMD_ADAPT, 0, 0, 65535, 0, 0));
        send_element(make_item(CMD_ADAPT, 0, 0, 65535, 0, 0));
        send_element(make_item(CMD_ADAPT, 31, 65535, 0, -1, 1));
        send_element(make_item(CMD_QUANT, 31, 7, 0, -32768, 1));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                write_reg(REG_ENTROPY_THRESHOLD, thr_set[p]);
                write_reg(REG_WINDOW_LIMIT, lim_set[p]);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                steady = (p == 2) && (sent < 80);
                if (p == 1 && sent >= 40 && !pressure_done)
                begin
                    hold_off_req  = 1'b1;
                    pressure_done = 1'b1;
                end
                send_random_token(sent);
            end
            steady = 1'b0;
        end

        drain_results();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS entropy_gated_kv_quantizer");
        else
            $display("FAIL entropy_gated_kv_quantizer");
        $finish;
    end

endmodule

/* sim.f */
sv/egkvq_pkg.sv
sv/egkvq_if.sv
sv/egkvq_encode.sv
sv/entropy_gated_kv_quantizer.sv
sv/egkvq_checker.sv
tb/testbench.sv
